### src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, sizes and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH          = 16;
    localparam int ELEMENT_WIDTH  = 16;
    localparam int PRIORITY_WIDTH = 16;
    localparam int COUNT_WIDTH    = 5;
    localparam int CMD_WIDTH      = 3;
    localparam int STATUS_WIDTH   = 2;

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_INSERT      = 3'd0,
        CMD_REMOVE_HEAD = 3'd1,
        CMD_REMOVE_ELEM = 3'd2,
        CMD_CHANGE_PRI  = 3'd3,
        CMD_CONTAINS    = 3'd4,
        CMD_CLEAR       = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        STATUS_SUCCESS     = 2'd0,
        STATUS_NOT_PRESENT = 2'd1,
        STATUS_FULL        = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_SEARCH,
        CELL_CLEAR
    } cell_op_t;

    typedef enum logic [1:0] {
        MATCH_ANY,
        MATCH_ELEM,
        MATCH_BOTH
    } match_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REINSERT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [CMD_WIDTH-1:0]      cmd;
        logic [ELEMENT_WIDTH-1:0]  element;
        logic [PRIORITY_WIDTH-1:0] priority_req;
        logic [PRIORITY_WIDTH-1:0] target_priority;
    } req_t;

    typedef struct packed {
        logic [STATUS_WIDTH-1:0]   status;
        logic                      found;
        logic [COUNT_WIDTH-1:0]    count;
        logic                      head_valid;
        logic [ELEMENT_WIDTH-1:0]  head_element;
        logic [PRIORITY_WIDTH-1:0] head_priority;
    } rsp_t;

    typedef struct packed {
        logic                      valid;
        logic [ELEMENT_WIDTH-1:0]  element;
        logic [PRIORITY_WIDTH-1:0] priority_val;
    } cell_data_t;

    typedef struct packed {
        cell_op_t                  op;
        match_t                    mode;
        logic [ELEMENT_WIDTH-1:0]  element;
        logic [PRIORITY_WIDTH-1:0] priority_val;
    } cell_cmd_t;

endpackage

### src/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Sorted priority queue built as a row of compare-and-shift slots, highest
// priority at slot 0, equal priorities in arrival order.
//
//   channel  direction  payload  handshake
//   req      in         req_t    req_valid / req_stall
//   rsp      out        rsp_t    rsp_valid / rsp_stall
//
// One response beat per request beat. Most commands pass EXEC and DONE;
// change priority, if found, also passes REINSERT, as the row first closes
// the gap and then opens a new one. Each step is one shift across the slot
// row. Reset empties the queue at once. A stalled response is held in its
// register while the next request goes ahead; that request then waits for
// the slot to free before its own response is loaded.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  spq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output spq_pkg::rsp_t rsp
);
    import spq_pkg::*;

    cell_cmd_t  cell_cmd;
    cell_data_t cell_data [DEPTH];
    logic       cell_ge   [DEPTH];
    logic       cell_seen [DEPTH];

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cell_cmd  (cell_cmd),
        .head      (cell_data[0]),
        .seen_out  (cell_seen[DEPTH-1])
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_data_t left;
        cell_data_t right;
        logic       left_ge;
        logic       seen_in;

        if (i == 0)
        begin : g_first
            assign left    = '0;
            assign left_ge = 1'b1;
            assign seen_in = 1'b0;
        end
        else
        begin : g_mid
            assign left    = cell_data[i-1];
            assign left_ge = cell_ge[i-1];
            assign seen_in = cell_seen[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right = '0;
        end
        else
        begin : g_inner
            assign right = cell_data[i+1];
        end

        spq_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cell_cmd),
            .left    (left),
            .left_ge (left_ge),
            .right   (right),
            .seen_in (seen_in),
            .data    (cell_data[i]),
            .ge      (cell_ge[i]),
            .seen    (cell_seen[i])
        );
    end

endmodule

### src/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds an entry, shifts it right on insert
// and left on delete, and flags priority and match results to neighbours.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  spq_pkg::cell_cmd_t cmd,
    input  spq_pkg::cell_data_t left,
    input  logic               left_ge,
    input  spq_pkg::cell_data_t right,
    input  logic               seen_in,
    output spq_pkg::cell_data_t data,
    output logic               ge,
    output logic               seen
);
    import spq_pkg::*;

    logic                      valid_reg;
    logic                      valid_next;
    logic [ELEMENT_WIDTH-1:0]  element_reg;
    logic [ELEMENT_WIDTH-1:0]  element_next;
    logic [PRIORITY_WIDTH-1:0] priority_reg;
    logic [PRIORITY_WIDTH-1:0] priority_next;
    logic                      hit;

    assign data = '{valid: valid_reg, element: element_reg, priority_val: priority_reg};
    assign ge   = valid_reg && (priority_reg >= cmd.priority_val);

    always_comb
    begin
        case (cmd.mode)
            MATCH_ANY:  hit = valid_reg;
            MATCH_ELEM: hit = valid_reg && (element_reg == cmd.element);
            MATCH_BOTH: hit = valid_reg && (element_reg == cmd.element)
                              && (priority_reg == cmd.priority_val);
            default:    hit = 1'b0;
        endcase
    end

    assign seen = seen_in || hit;

    always_comb
    begin
        valid_next    = valid_reg;
        element_next  = element_reg;
        priority_next = priority_reg;
        case (cmd.op)
            CELL_INSERT:
            begin
                if (!ge)
                begin
                    if (left_ge)
                    begin
                        valid_next    = 1'b1;
                        element_next  = cmd.element;
                        priority_next = cmd.priority_val;
                    end
                    else
                    begin
                        valid_next    = left.valid;
                        element_next  = left.element;
                        priority_next = left.priority_val;
                    end
                end
            end
            CELL_DELETE:
            begin
                if (seen)
                begin
                    valid_next    = right.valid;
                    element_next  = right.element;
                    priority_next = right.priority_val;
                end
            end
            CELL_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        element_reg  <= element_next;
        priority_reg <= priority_next;
    end

endmodule

### src/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Command sequencer: takes request beats, drives the cell row, keeps the
// entry count and builds the response beat.
// ----------------------------------------------------------------------------
module spq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  spq_pkg::req_t       req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output spq_pkg::rsp_t       rsp,
    output spq_pkg::cell_cmd_t  cell_cmd,
    input  spq_pkg::cell_data_t head,
    input  logic                seen_out
);
    import spq_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(DEPTH);
    localparam logic [COUNT_WIDTH-1:0] ONE        = COUNT_WIDTH'(1);

    state_t                  state_reg;
    state_t                  state_next;
    req_t                    req_reg;
    req_t                    req_next;
    logic [COUNT_WIDTH-1:0]  count_reg;
    logic [COUNT_WIDTH-1:0]  count_next;
    logic [STATUS_WIDTH-1:0] status_reg;
    logic [STATUS_WIDTH-1:0] status_next;
    logic                    found_reg;
    logic                    found_next;
    logic                    rsp_valid_reg;
    logic                    rsp_valid_next;
    rsp_t                    rsp_reg;
    rsp_t                    rsp_next;
    logic                    rsp_free;
    logic                    accept;

    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !((state_reg == ST_IDLE) || ((state_reg == ST_DONE) && rsp_free));
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        cell_cmd       = '{op: CELL_HOLD, mode: MATCH_ANY, element: req_reg.element,
                           priority_val: req_reg.priority_req};

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                case (req_reg.cmd)
                    CMD_INSERT:
                    begin
                        if (count_reg == FULL_COUNT)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            cell_cmd.op = CELL_INSERT;
                            count_next  = count_reg + ONE;
                        end
                    end
                    CMD_REMOVE_HEAD:
                    begin
                        cell_cmd.op   = CELL_DELETE;
                        cell_cmd.mode = MATCH_ANY;
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - ONE;
                        end
                    end
                    CMD_REMOVE_ELEM:
                    begin
                        cell_cmd.op   = CELL_DELETE;
                        cell_cmd.mode = MATCH_ELEM;
                        if (seen_out)
                        begin
                            count_next = count_reg - ONE;
                        end
                        else
                        begin
                            status_next = STATUS_NOT_PRESENT;
                        end
                    end
                    CMD_CHANGE_PRI:
                    begin
                        cell_cmd.op   = CELL_DELETE;
                        cell_cmd.mode = MATCH_BOTH;
                        if (seen_out)
                        begin
                            state_next = ST_REINSERT;
                        end
                        else
                        begin
                            status_next = STATUS_NOT_PRESENT;
                        end
                    end
                    CMD_CONTAINS:
                    begin
                        cell_cmd.op   = CELL_SEARCH;
                        cell_cmd.mode = MATCH_ELEM;
                        found_next    = seen_out;
                    end
                    CMD_CLEAR:
                    begin
                        cell_cmd.op = CELL_CLEAR;
                        count_next  = '0;
                    end
                    default:
                    begin
                        cell_cmd.op = CELL_HOLD;
                    end
                endcase
            end
            ST_REINSERT:
            begin
                cell_cmd.op           = CELL_INSERT;
                cell_cmd.priority_val = req_reg.target_priority;
                state_next            = ST_DONE;
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.status       = status_reg;
                    rsp_next.found        = found_reg;
                    rsp_next.count        = count_reg;
                    rsp_next.head_valid   = head.valid;
                    rsp_next.head_element = head.valid ? head.element : '0;
                    rsp_next.head_priority = head.valid ? head.priority_val : '0;
                    state_next            = accept ? ST_EXEC : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (accept)
        begin
            req_next    = req;
            status_next = STATUS_SUCCESS;
            found_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        rsp_reg    <= rsp_next;
    end

endmodule
